/* hdl/swdh_pkg.sv */
package swdh_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_INIT = 2'd1,
    PH_RUN  = 2'd2,
    PH_STOP = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    PIN_REL = 2'd0,
    PIN_HI  = 2'd1,
    PIN_LO  = 2'd2
  } pin_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FAULT = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;
  localparam logic [1:0] ST_BUS   = 2'd3;

  localparam logic [2:0] ACK_OK    = 3'b001;
  localparam logic [2:0] ACK_WAIT  = 3'b010;
  localparam logic [2:0] ACK_FAULT = 3'b100;

  localparam logic [7:0] WAKE_ONES = 8'hff;
  localparam logic [7:0] WAKE_SW0  = 8'h9e;
  localparam logic [7:0] WAKE_SW1  = 8'he7;

  localparam logic [7:0] WAKE_LEN = 8'd128;
  localparam logic [7:0] STOP_LEN = 8'd8;

  localparam logic [5:0] POS_TURN    = 6'd8;
  localparam logic [5:0] POS_ACK_END = 6'd11;
  localparam logic [5:0] POS_DATA    = 6'd12;
  localparam logic [5:0] POS_WDATA   = 6'd13;
  localparam logic [5:0] POS_RD_END  = 6'd44;
  localparam logic [5:0] POS_LAST    = 6'd45;

  typedef struct packed {
    logic        is_write;
    logic [7:0]  request;
    logic [31:0] word;
  } entry_t;

  typedef struct packed {
    logic        accepted;
    logic        clock_active;
    pin_t        dio_mode;
    logic        done_res;
    logic [1:0]  status;
    logic [31:0] read_data;
  } res_t;

  function automatic logic wake_bit(input logic [6:0] s);
    logic [7:0] b;
    case (s[6:3])
      4'd7:    b = WAKE_SW0;
      4'd8:    b = WAKE_SW1;
      default: b = WAKE_ONES;
    endcase
    return b[s[2:0]];
  endfunction

  function automatic pin_t drive_bit(input logic b);
    return b ? PIN_HI : PIN_LO;
  endfunction

  function automatic logic [1:0] ack_status(input logic [2:0] a);
    logic [1:0] s;
    case (a)
      ACK_FAULT: s = ST_FAULT;
      ACK_WAIT:  s = ST_BUSY;
      default:   s = ST_BUS;
    endcase
    return s;
  endfunction

endpackage

/* hdl/swdh_queue.sv */
module swdh_queue #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            enq_valid,
  input  swdh_pkg::entry_t enq_entry,
  output logic            enq_ok,
  input  logic            deq,
  output logic            empty,
  output swdh_pkg::entry_t head_entry
);
  import swdh_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

  entry_t        mem [QUEUE_DEPTH];
  entry_t        rd_r;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [AW-1:0] tail_inc, head_inc;
  logic          we;

  assign tail_inc = (tail_r == LAST) ? '0 : tail_r + 1'b1;
  assign head_inc = (head_r == LAST) ? '0 : head_r + 1'b1;
  assign empty    = (head_r == tail_r);
  assign enq_ok   = (tail_inc != head_r);
  assign we       = enq_valid && enq_ok;
  assign tail_nxt = we ? tail_inc : tail_r;
  assign head_nxt = deq ? head_inc : head_r;
  assign head_entry = rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  // head word is kept registered, with the write bypassed onto it
  always_ff @(posedge clk) begin
    if (we) begin
      mem[tail_r] <= enq_entry;
    end
    if (we && (tail_r == head_nxt)) begin
      rd_r <= enq_entry;
    end else begin
      rd_r <= mem[head_nxt];
    end
  end

endmodule

/* hdl/swdh_engine.sv */
module swdh_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tick,
  input  logic             dio_in,
  input  logic             q_empty,
  input  swdh_pkg::entry_t head_entry,
  output logic             deq,
  output swdh_pkg::res_t   res
);
  import swdh_pkg::*;

  phase_t      phase_r, phase_nxt;
  pin_t        pin_r, pin_nxt;
  logic [7:0]  seq_r, seq_nxt, seq_inc;
  logic [5:0]  pos_r, pos_nxt;
  logic [2:0]  ack_r, ack_nxt;
  logic        wr_r, wr_nxt;
  logic [7:0]  req_r, req_nxt;
  logic [31:0] word_r, word_nxt;

  logic        run_done;
  logic [1:0]  run_st;
  logic [31:0] run_rd;
  pin_t        run_pin;
  logic [2:0]  run_ack;
  logic [31:0] run_word;
  logic [5:0]  run_pos;
  logic [5:0]  rd_off, wr_off;
  logic [2:0]  ack_new;
  logic        load;

  assign seq_inc = seq_r + 8'd1;
  assign rd_off  = pos_r - POS_DATA;
  assign wr_off  = pos_r - POS_WDATA;

  // one bit of the active transaction
  always_comb begin
    run_done = 1'b0;
    run_st   = ST_OK;
    run_rd   = '0;
    run_pin  = pin_r;
    run_ack  = ack_r;
    run_word = word_r;
    ack_new  = ack_r;
    ack_new[pos_r[1:0] - 2'd1] = ack_r[pos_r[1:0] - 2'd1] | dio_in;
    if (pos_r < POS_TURN) begin
      run_pin = drive_bit(req_r[pos_r[2:0]]);
    end else if (pos_r == POS_TURN) begin
      run_pin = PIN_REL;
      run_ack = '0;
    end else if (pos_r <= POS_ACK_END) begin
      run_ack = ack_new;
      if ((pos_r == POS_ACK_END) && !wr_r) begin
        if (ack_new != ACK_OK) begin
          run_done = 1'b1;
          run_st   = ack_status(ack_new);
        end else begin
          run_word = '0;
        end
      end
    end else if (!wr_r) begin
      if (pos_r < POS_RD_END) begin
        run_word[rd_off[4:0]] = word_r[rd_off[4:0]] | dio_in;
      end else if (pos_r == POS_RD_END) begin
        run_word = word_r;
      end else if (pos_r == POS_LAST) begin
        run_pin  = PIN_HI;
        run_done = 1'b1;
        run_st   = ST_OK;
        run_rd   = word_r;
      end else begin
        run_done = 1'b1;
        run_st   = ST_BUS;
      end
    end else begin
      if (pos_r == POS_DATA) begin
        run_pin = PIN_HI;
        if (ack_r != ACK_OK) begin
          run_done = 1'b1;
          run_st   = ack_status(ack_r);
        end
      end else if (pos_r < POS_LAST) begin
        run_pin = drive_bit(word_r[wr_off[4:0]]);
      end else if (pos_r == POS_LAST) begin
        run_pin  = drive_bit(^word_r);
        run_done = 1'b1;
        run_st   = ST_OK;
      end else begin
        run_done = 1'b1;
        run_st   = ST_BUS;
      end
    end
    run_pos = run_done ? pos_r : pos_r + 6'd1;
  end

  // bus phase sequencing
  always_comb begin
    phase_nxt = phase_r;
    pin_nxt   = pin_r;
    seq_nxt   = seq_r;
    pos_nxt   = pos_r;
    ack_nxt   = ack_r;
    wr_nxt    = wr_r;
    req_nxt   = req_r;
    word_nxt  = word_r;
    load      = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        pin_nxt = PIN_REL;
        if (!q_empty) begin
          seq_nxt   = '0;
          phase_nxt = PH_INIT;
        end
      end
      PH_INIT: begin
        pin_nxt = drive_bit(wake_bit(seq_r[6:0]));
        seq_nxt = seq_inc;
        if (seq_inc >= WAKE_LEN) begin
          if (!q_empty) begin
            load = 1'b1;
          end else begin
            seq_nxt   = '0;
            phase_nxt = PH_STOP;
          end
        end
      end
      PH_RUN: begin
        pin_nxt  = run_pin;
        ack_nxt  = run_ack;
        word_nxt = run_word;
        pos_nxt  = run_pos;
        if (run_done) begin
          if (!q_empty) begin
            load = 1'b1;
          end else begin
            seq_nxt   = '0;
            phase_nxt = PH_STOP;
          end
        end
      end
      PH_STOP: begin
        pin_nxt = PIN_HI;
        seq_nxt = seq_inc;
        if (seq_inc >= STOP_LEN) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    if (load) begin
      phase_nxt = PH_RUN;
      wr_nxt    = head_entry.is_write;
      req_nxt   = head_entry.request;
      word_nxt  = head_entry.word;
      pos_nxt   = '0;
      ack_nxt   = '0;
    end
  end

  assign deq = tick && load;

  // result of this tick
  always_comb begin
    res              = '0;
    res.clock_active = (phase_nxt != PH_IDLE);
    res.dio_mode     = pin_nxt;
    if ((phase_r == PH_RUN) && run_done) begin
      res.done_res  = 1'b1;
      res.status    = run_st;
      res.read_data = run_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pin_r   <= PIN_REL;
      seq_r   <= '0;
      pos_r   <= '0;
      ack_r   <= '0;
      wr_r    <= 1'b0;
      req_r   <= '0;
      word_r  <= '0;
    end else if (tick) begin
      phase_r <= phase_nxt;
      pin_r   <= pin_nxt;
      seq_r   <= seq_nxt;
      pos_r   <= pos_nxt;
      ack_r   <= ack_nxt;
      wr_r    <= wr_nxt;
      req_r   <= req_nxt;
      word_r  <= word_nxt;
    end
  end

endmodule

/* hdl/swd_host_transaction_engine.sv */
// serial wire debug host: queues read/write transactions and runs them on
// the bus, one bus bit per tick request.
// input channel: in_tuser carries the command (bus tick, queue read, queue
// write); in_tdata carries the request byte, write word and sampled pin level.
// a queue request answers with accepted (0 when the ring holds
// QUEUE_DEPTH-1 entries); a tick request answers with clock_active, the pin
// drive mode for the next low clock phase, and on completion of a
// transaction done_res, status and read_data.
// every request gives exactly one result on the output channel.
// a request is registered on input, then its result is registered on output
// once the output register is free or being taken, which raises out_tvalid.
// throughput: one request per cycle while out_tready is high, set by the
// single registered pass: input register, bus sequencer, output register.
// reset (rst_n low, synchronous) empties the queue, puts the bus in idle and
// releases the pin; no clearing pass is needed.
// when out_tready is low the result is held and in_tready drops once the
// input register is also full; nothing is lost or repeated.
module swd_host_transaction_engine #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // request[7:0], write_data[39:8], dio_in[40], zero
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // accepted, clock_active, dio_mode[3:2],
                                  // done_res, status[6:5], read_data[38:7], zero
);
  import swdh_pkg::*;

  logic        in_valid_r;
  logic [1:0]  cmd_r;
  logic [7:0]  req_r;
  logic [31:0] wd_r;
  logic        din_r;
  logic        out_valid_r;
  res_t        out_r, out_nxt;
  logic        advance, fire;
  logic        is_queue, is_tick;
  logic        enq_ok, deq, q_empty;
  entry_t      enq_entry, head_entry;
  res_t        eng_res;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  assign is_queue = (cmd_r == CMD_READ) || (cmd_r == CMD_WRITE);
  assign is_tick  = (cmd_r == CMD_TICK);

  assign enq_entry.is_write = (cmd_r == CMD_WRITE);
  assign enq_entry.request  = req_r;
  assign enq_entry.word     = (cmd_r == CMD_WRITE) ? wd_r : '0;

  swdh_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .enq_valid  (fire && is_queue),
    .enq_entry  (enq_entry),
    .enq_ok     (enq_ok),
    .deq        (deq),
    .empty      (q_empty),
    .head_entry (head_entry)
  );

  swdh_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (fire && is_tick),
    .dio_in     (din_r),
    .q_empty    (q_empty),
    .head_entry (head_entry),
    .deq        (deq),
    .res        (eng_res)
  );

  always_comb begin
    out_nxt = '0;
    case (cmd_r)
      CMD_READ, CMD_WRITE: out_nxt.accepted = enq_ok;
      CMD_TICK:            out_nxt = eng_res;
      default:             out_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r <= in_tuser;
      req_r <= in_tdata[7:0];
      wd_r  <= in_tdata[39:8];
      din_r <= in_tdata[40];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r.read_data, out_r.status, out_r.done_res,
                       out_r.dio_mode, out_r.clock_active, out_r.accepted};

endmodule

/* tb/tb.sv */
module tb;
  import swdh_pkg::*;

  localparam int RING_SLOTS = 8;
  localparam int ENTRY_W = $bits(entry_t);
  localparam int ITEM_TARGET = 1150;
  localparam int QUIET_TAIL = 150;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam logic [127:0] WAKE_PATTERN = {{7{WAKE_ONES}}, WAKE_SW1, WAKE_SW0, {7{WAKE_ONES}}};

  typedef struct packed {
    phase_t                          phase;
    logic [7:0]                      seq;
    logic [RING_SLOTS*ENTRY_W-1:0]   ring;
    logic [2:0]                      head;
    logic [2:0]                      tail;
    logic                            wr;
    logic [7:0]                      req;
    logic [31:0]                     word;
    logic [5:0]                      pos;
    logic [2:0]                      ack;
    pin_t                            pin;
  } bus_model_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  req;
    logic [31:0] wd;
    logic        din;
  } host_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // request, write_data, dio_in, zero
  logic [1:0]  in_tuser = '0;   // command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // accepted, clock_active, dio_mode, done_res, status, read_data

  bus_model_t  bus_model;
  bus_model_t  plan_model;
  host_req_t   pending_reqs[$];
  res_t        expected_results[$];
  logic [2:0]  forced_acks[$];
  logic [2:0]  planned_ack;

  int mismatches = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_stall = 0;
  int recv_calm = 0;
  int reads_queued = 0;
  int writes_queued = 0;
  int refused = 0;
  int ignored = 0;
  int done_by_status[4] = '{0, 0, 0, 0};

  swd_host_transaction_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  function automatic pin_t pin_for(input logic b);
    if (b) return PIN_HI;
    return PIN_LO;
  endfunction

  function automatic logic [1:0] ack_to_status(input logic [2:0] a);
    if (a == ACK_FAULT) return ST_FAULT;
    else if (a == ACK_WAIT) return ST_BUSY;
    return ST_BUS;
  endfunction

  function automatic logic pop_transaction(inout bus_model_t m);
    entry_t e;
    if (m.head == m.tail) return 1'b0;
    e = m.ring[m.head*ENTRY_W +: ENTRY_W];
    m.head = m.head + 3'd1;
    m.wr = e.is_write;
    m.req = e.request;
    m.word = e.word;
    m.pos = '0;
    m.ack = '0;
    return 1'b1;
  endfunction

  // one request through the host: queue access or one bus bit
  function automatic res_t host_step(inout bus_model_t m, input logic [1:0] cmd,
                                     input logic [7:0] req, input logic [31:0] wd,
                                     input logic din);
    res_t       r;
    entry_t     e;
    logic [2:0] nt;
    logic       finished;
    logic [1:0] st;
    logic [31:0] rd;
    logic [5:0] p;
    r = '0;
    finished = 1'b0;
    st = ST_OK;
    rd = '0;
    if (cmd == CMD_READ || cmd == CMD_WRITE) begin
      nt = m.tail + 3'd1;
      if (nt != m.head) begin
        e.is_write = (cmd == CMD_WRITE);
        e.request = req;
        e.word = (cmd == CMD_WRITE) ? wd : 32'd0;
        m.ring[m.tail*ENTRY_W +: ENTRY_W] = e;
        m.tail = nt;
        r.accepted = 1'b1;
      end
      return r;
    end
    if (cmd != CMD_TICK) return r;

    case (m.phase)
      PH_IDLE: begin
        m.pin = PIN_REL;
        if (m.head != m.tail) begin
          m.seq = '0;
          m.phase = PH_INIT;
        end
      end
      PH_INIT: begin
        m.pin = pin_for(WAKE_PATTERN[m.seq[6:0]]);
        m.seq = m.seq + 8'd1;
        if (m.seq >= WAKE_LEN) begin
          if (pop_transaction(m)) begin
            m.phase = PH_RUN;
          end else begin
            m.seq = '0;
            m.phase = PH_STOP;
          end
        end
      end
      PH_RUN: begin
        p = m.pos;
        if (p < POS_TURN) begin
          m.pin = pin_for(m.req[p[2:0]]);
        end else if (p == POS_TURN) begin
          m.pin = PIN_REL;
          m.ack = '0;
        end else if (p <= POS_ACK_END) begin
          m.ack = m.ack | (3'(din) << (p - POS_TURN - 6'd1));
          if (p == POS_ACK_END && !m.wr) begin
            if (m.ack != ACK_OK) begin
              finished = 1'b1;
              st = ack_to_status(m.ack);
            end else begin
              m.word = '0;
            end
          end
        end else if (!m.wr) begin
          if (p < POS_RD_END) begin
            m.word = m.word | (32'(din) << (p - POS_DATA));
          end else if (p == POS_LAST) begin
            m.pin = PIN_HI;
            finished = 1'b1;
            st = ST_OK;
            rd = m.word;
          end else if (p > POS_LAST) begin
            finished = 1'b1;
            st = ST_BUS;
          end
        end else begin
          if (p == POS_DATA) begin
            m.pin = PIN_HI;
            if (m.ack != ACK_OK) begin
              finished = 1'b1;
              st = ack_to_status(m.ack);
            end
          end else if (p < POS_LAST) begin
            m.pin = pin_for(m.word[p - POS_WDATA]);
          end else if (p == POS_LAST) begin
            m.pin = pin_for(^m.word);
            finished = 1'b1;
            st = ST_OK;
          end else begin
            finished = 1'b1;
            st = ST_BUS;
          end
        end
        if (!finished) begin
          m.pos = p + 6'd1;
        end else begin
          r.done_res = 1'b1;
          r.status = st;
          r.read_data = rd;
          if (!pop_transaction(m)) begin
            m.seq = '0;
            m.phase = PH_STOP;
          end
        end
      end
      default: begin
        m.pin = PIN_HI;
        m.seq = m.seq + 8'd1;
        if (m.seq >= STOP_LEN) m.phase = PH_IDLE;
      end
    endcase

    r.clock_active = (m.phase != PH_IDLE);
    r.dio_mode = m.pin;
    return r;
  endfunction

  // appends a request; during the acknowledge window the pin level follows a planned code
  task automatic add_item(input logic [1:0] cmd, input logic [7:0] req,
                          input logic [31:0] wd, input logic din);
    host_req_t  it;
    res_t       r;
    logic [5:0] p;
    int         pick;
    it.cmd = cmd;
    it.req = req;
    it.wd = wd;
    it.din = din;
    p = plan_model.pos;
    if (cmd == CMD_TICK && plan_model.phase == PH_RUN && p > POS_TURN && p <= POS_ACK_END) begin
      if (p == POS_TURN + 6'd1) begin
        if (forced_acks.size() != 0) begin
          planned_ack = forced_acks.pop_front();
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 65) planned_ack = ACK_OK;
          else if (pick < 75) planned_ack = ACK_WAIT;
          else if (pick < 85) planned_ack = ACK_FAULT;
          else planned_ack = 3'($urandom);
        end
      end
      it.din = planned_ack[p - POS_TURN - 6'd1];
    end
    r = host_step(plan_model, it.cmd, it.req, it.wd, it.din);
    if (cmd == CMD_READ || cmd == CMD_WRITE) begin
      if (!r.accepted) refused++;
      else if (cmd == CMD_WRITE) writes_queued++;
      else reads_queued++;
    end else if (cmd == CMD_NONE) begin
      ignored++;
    end
    pending_reqs.push_back(it);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // driver
  always @(posedge clk) begin : driver
    host_req_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(host_step(bus_model, in_tuser, in_tdata[7:0],
                                             in_tdata[39:8], in_tdata[40]));
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (send_calm == 0 && pending_reqs.size() > QUIET_TAIL &&
                     $urandom_range(0, 99) < 6) begin
          send_gap = $urandom_range(0, 18);
          in_tvalid <= 1'b0;
        end else begin
          if (send_calm > 0) send_calm--;
          else if ($urandom_range(0, 99) < 2) send_calm = $urandom_range(30, 150);
          it = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= it.cmd;
          in_tdata <= {7'd0, it.din, it.wd, it.req};
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    res_t want;
    int   pick;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 40)
            $display("%0t: result with no request outstanding, actual %0h", $time, out_tdata);
        end else begin
          want = expected_results.pop_front();
          if (want.done_res) done_by_status[want.status]++;
          check_field("accepted", 32'(want.accepted), 32'(out_tdata[0]));
          check_field("clock_active", 32'(want.clock_active), 32'(out_tdata[1]));
          check_field("dio_mode", 32'(want.dio_mode), 32'(out_tdata[3:2]));
          check_field("done_res", 32'(want.done_res), 32'(out_tdata[4]));
          check_field("status", 32'(want.status), 32'(out_tdata[6:5]));
          check_field("read_data", want.read_data, out_tdata[38:7]);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else if (recv_calm > 0) begin
        recv_calm--;
        out_tready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pending_reqs.size() > QUIET_TAIL && pick < 7) begin
          recv_stall = $urandom_range(0, 18);
          out_tready <= 1'b0;
        end else begin
          if (pick >= 97) recv_calm = $urandom_range(30, 150);
          out_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int pick;
    int n;
    bus_model = '0;
    plan_model = '0;
    forced_acks = '{ACK_OK, ACK_WAIT, ACK_FAULT, 3'b000, 3'b111, ACK_OK, ACK_OK};

    // directed: ignored command, idle ticks, ring fill and refusal
    add_item(CMD_NONE, 8'hff, 32'hffff_ffff, 1'b1);
    add_item(CMD_NONE, 8'h00, 32'h0000_0000, 1'b0);
    add_item(CMD_TICK, 8'h00, 32'h0000_0000, 1'b0);
    add_item(CMD_TICK, 8'hff, 32'hffff_ffff, 1'b1);
    add_item(CMD_READ, 8'h00, 32'hffff_ffff, 1'b1);
    add_item(CMD_WRITE, 8'hff, 32'hffff_ffff, 1'b0);
    add_item(CMD_READ, 8'hff, 32'h0000_0000, 1'b0);
    add_item(CMD_WRITE, 8'h00, 32'h0000_0000, 1'b1);
    add_item(CMD_READ, 8'ha5, 32'h1234_5678, 1'b0);
    add_item(CMD_WRITE, 8'h5a, 32'h0000_0001, 1'b1);
    add_item(CMD_WRITE, 8'h81, 32'h8000_0003, 1'b0);
    add_item(CMD_WRITE, 8'h3c, 32'hdead_beef, 1'b1);
    add_item(CMD_READ, 8'hc3, 32'h0f0f_0f0f, 1'b0);
    add_item(CMD_NONE, 8'h7e, 32'h5555_aaaa, 1'b1);

    // random: bursts of queued transactions with clean or broken acknowledges
    while (pending_reqs.size() < ITEM_TARGET || plan_model.phase != PH_IDLE ||
           plan_model.head != plan_model.tail) begin
      if (plan_model.phase == PH_IDLE && plan_model.head == plan_model.tail) begin
        if ($urandom_range(0, 9) == 0) begin
          add_item($urandom_range(0, 1) ? CMD_TICK : CMD_NONE, 8'($urandom),
                   32'($urandom), 1'($urandom));
        end else begin
          n = $urandom_range(1, 9);
          repeat (n) add_item($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, 8'($urandom),
                              32'($urandom), 1'($urandom));
        end
      end else begin
        pick = $urandom_range(0, 199);
        if (pending_reqs.size() < ITEM_TARGET && pick < 3)
          add_item($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, 8'($urandom),
                   32'($urandom), 1'($urandom));
        else if (pick < 6)
          add_item(CMD_NONE, 8'($urandom), 32'($urandom), 1'($urandom));
        else
          add_item(CMD_TICK, 8'($urandom), 32'($urandom), 1'($urandom));
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_reqs.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
    end
    $display("ran %0d reads and %0d writes through the ring, %0d refused when full, %0d ignored",
             reads_queued, writes_queued, refused, ignored);
    $display("transactions ended ok %0d, fault %0d, wait %0d, bus error %0d",
             done_by_status[ST_OK], done_by_status[ST_FAULT], done_by_status[ST_BUSY],
             done_by_status[ST_BUS]);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/swdh_pkg.sv
hdl/swdh_queue.sv
hdl/swdh_engine.sv
hdl/swd_host_transaction_engine.sv
tb/tb.sv
